// ----- rtl/crgb_pkg.sv -----
`timescale 1ns / 1ps

package crgb_pkg;

    localparam logic [1:0] FMT_BGRA = 2'd0;
    localparam logic [1:0] FMT_YUYV = 2'd1;
    localparam logic [1:0] FMT_NV12 = 2'd2;

    localparam int SUM_W = 20;

    localparam logic signed [SUM_W-1:0] K_Y   = 20'sd298;
    localparam logic signed [SUM_W-1:0] K_RV  = 20'sd409;
    localparam logic signed [SUM_W-1:0] K_GU  = 20'sd100;
    localparam logic signed [SUM_W-1:0] K_GV  = 20'sd208;
    localparam logic signed [SUM_W-1:0] K_BU  = 20'sd516;
    localparam logic signed [SUM_W-1:0] ROUND = 20'sd128;
    localparam logic signed [SUM_W-1:0] Y_OFS = 20'sd16;
    localparam logic signed [SUM_W-1:0] C_OFS = 20'sd128;

    typedef struct packed {
        logic [7:0] first_byte;
        logic [7:0] second_byte;
        logic [7:0] third_byte;
        logic [7:0] fourth_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       last_of_item;
    } out_item_t;

    // In pass-through mode y, u and v carry red, green and blue.
    typedef struct packed {
        logic       bypass;
        logic       last;
        logic [7:0] y;
        logic [7:0] u;
        logic [7:0] v;
    } pixel_t;

    typedef struct packed {
        logic                    bypass;
        logic                    last;
        logic [7:0]              raw_r;
        logic [7:0]              raw_g;
        logic [7:0]              raw_b;
        logic signed [SUM_W-1:0] p_y;
        logic signed [SUM_W-1:0] p_rv;
        logic signed [SUM_W-1:0] p_gu;
        logic signed [SUM_W-1:0] p_gv;
        logic signed [SUM_W-1:0] p_bu;
    } prod_t;

    typedef struct packed {
        logic                    last;
        logic signed [SUM_W-1:0] r;
        logic signed [SUM_W-1:0] g;
        logic signed [SUM_W-1:0] b;
    } sum_t;

    function automatic logic [7:0] clamp8(input logic signed [SUM_W-1:0] s);
        logic [7:0] res;
        if (s[SUM_W-1])
        begin
            res = 8'h00;
        end
        else if (s[SUM_W-2:16] != '0)
        begin
            res = 8'hFF;
        end
        else
        begin
            res = s[15:8];
        end
        return res;
    endfunction

endpackage

// ----- rtl/camera_pixel_to_rgb_converter_top.sv -----
// Each pixel passes through word_reg, pix_reg, prod_reg, sum_reg and out_item_reg in turn.
// Throughput: one pixel per cycle while out_stall is low, set by the single-pixel path
// through the multiply pipeline; BGRA and NV12 items give one pixel each, YUYV items two.
// Items with the unused format code are dropped with no pixel.
// Reset (rst_n, asynchronous, active low) empties the pipeline and sets the format to BGRA.
`timescale 1ns / 1ps

module camera_pixel_to_rgb_converter_top
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_data,
    input  logic                in_valid,
    output logic                in_stall,
    input  crgb_pkg::in_item_t  in_item,
    output logic                out_valid,
    input  logic                out_stall,
    output crgb_pkg::out_item_t out_item
);

    logic [1:0]       fmt_reg;
    logic             pix_valid;
    logic             pix_ready;
    crgb_pkg::pixel_t pix;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt_reg <= crgb_pkg::FMT_BGRA;
        end
        else if (cfg_valid && cfg_ready)
        begin
            fmt_reg <= cfg_data;
        end
    end

    crgb_unpack u_unpack
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .pixel_format (fmt_reg),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .in_item      (in_item),
        .pix_valid    (pix_valid),
        .pix_ready    (pix_ready),
        .pix          (pix)
    );

    crgb_color u_color
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix_valid (pix_valid),
        .pix_ready (pix_ready),
        .pix       (pix),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

endmodule

// ----- rtl/crgb_unpack.sv -----
`timescale 1ns / 1ps

module crgb_unpack
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [1:0]          pixel_format,
    input  logic                in_valid,
    output logic                in_stall,
    input  crgb_pkg::in_item_t  in_item,
    output logic                pix_valid,
    input  logic                pix_ready,
    output crgb_pkg::pixel_t    pix
);

    logic               word_valid_reg;
    logic               word_valid_next;
    crgb_pkg::in_item_t word_reg;
    logic [1:0]         fmt_reg;
    logic               phase_reg;
    logic               phase_next;
    logic               pix_valid_reg;
    crgb_pkg::pixel_t   pix_reg;

    crgb_pkg::pixel_t   cur_pix;
    logic               cur_emit;
    logic               cur_final;
    logic               word_done;
    logic               stage_ready;
    logic               in_ready;

    always_comb
    begin
        cur_pix   = '0;
        cur_emit  = 1'b1;
        cur_final = 1'b1;
        unique case (fmt_reg)
            crgb_pkg::FMT_BGRA:
            begin
                cur_pix.bypass = 1'b1;
                cur_pix.last   = 1'b1;
                cur_pix.y      = word_reg.third_byte;
                cur_pix.u      = word_reg.second_byte;
                cur_pix.v      = word_reg.first_byte;
            end
            crgb_pkg::FMT_YUYV:
            begin
                cur_pix.last = phase_reg;
                cur_pix.y    = phase_reg ? word_reg.third_byte : word_reg.first_byte;
                cur_pix.u    = word_reg.second_byte;
                cur_pix.v    = word_reg.fourth_byte;
                cur_final    = phase_reg;
            end
            crgb_pkg::FMT_NV12:
            begin
                cur_pix.last = 1'b1;
                cur_pix.y    = word_reg.first_byte;
                cur_pix.u    = word_reg.second_byte;
                cur_pix.v    = word_reg.third_byte;
            end
            default:
            begin
                cur_emit = 1'b0;
            end
        endcase
    end

    assign stage_ready = !pix_valid_reg || pix_ready;
    assign word_done   = word_valid_reg && (!cur_emit || (stage_ready && cur_final));
    assign in_ready    = !word_valid_reg || word_done;
    assign in_stall    = !in_ready;

    always_comb
    begin
        word_valid_next = word_valid_reg;
        phase_next      = phase_reg;
        if (in_valid && in_ready)
        begin
            word_valid_next = 1'b1;
            phase_next      = 1'b0;
        end
        else if (word_done)
        begin
            word_valid_next = 1'b0;
            phase_next      = 1'b0;
        end
        else if (word_valid_reg && cur_emit && stage_ready)
        begin
            phase_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_valid_reg <= 1'b0;
            phase_reg      <= 1'b0;
            pix_valid_reg  <= 1'b0;
        end
        else
        begin
            word_valid_reg <= word_valid_next;
            phase_reg      <= phase_next;
            if (stage_ready)
            begin
                pix_valid_reg <= word_valid_reg && cur_emit;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            word_reg <= in_item;
            fmt_reg  <= pixel_format;
        end
        if (stage_ready)
        begin
            pix_reg <= cur_pix;
        end
    end

    assign pix_valid = pix_valid_reg;
    assign pix       = pix_reg;

endmodule

// ----- rtl/crgb_color.sv -----
`timescale 1ns / 1ps

module crgb_color
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                pix_valid,
    output logic                pix_ready,
    input  crgb_pkg::pixel_t    pix,
    output logic                out_valid,
    input  logic                out_stall,
    output crgb_pkg::out_item_t out_item
);

    logic                prod_valid_reg;
    crgb_pkg::prod_t     prod_reg;
    crgb_pkg::prod_t     prod_next;
    logic                sum_valid_reg;
    crgb_pkg::sum_t      sum_reg;
    crgb_pkg::sum_t      sum_next;
    logic                out_valid_reg;
    crgb_pkg::out_item_t out_item_reg;
    crgb_pkg::out_item_t out_item_next;

    logic signed [crgb_pkg::SUM_W-1:0] c_val;
    logic signed [crgb_pkg::SUM_W-1:0] d_val;
    logic signed [crgb_pkg::SUM_W-1:0] e_val;

    logic out_ready;
    logic sum_ready;
    logic prod_ready;

    assign out_ready  = !out_valid_reg || !out_stall;
    assign sum_ready  = !sum_valid_reg || out_ready;
    assign prod_ready = !prod_valid_reg || sum_ready;
    assign pix_ready  = prod_ready;

    always_comb
    begin
        c_val = $signed({{(crgb_pkg::SUM_W-8){1'b0}}, pix.y}) - crgb_pkg::Y_OFS;
        d_val = $signed({{(crgb_pkg::SUM_W-8){1'b0}}, pix.u}) - crgb_pkg::C_OFS;
        e_val = $signed({{(crgb_pkg::SUM_W-8){1'b0}}, pix.v}) - crgb_pkg::C_OFS;
        prod_next.bypass = pix.bypass;
        prod_next.last   = pix.last;
        prod_next.raw_r  = pix.y;
        prod_next.raw_g  = pix.u;
        prod_next.raw_b  = pix.v;
        prod_next.p_y    = c_val * crgb_pkg::K_Y;
        prod_next.p_rv   = e_val * crgb_pkg::K_RV;
        prod_next.p_gu   = d_val * crgb_pkg::K_GU;
        prod_next.p_gv   = e_val * crgb_pkg::K_GV;
        prod_next.p_bu   = d_val * crgb_pkg::K_BU;
    end

    always_comb
    begin
        sum_next.last = prod_reg.last;
        if (prod_reg.bypass)
        begin
            sum_next.r = $signed({{(crgb_pkg::SUM_W-16){1'b0}}, prod_reg.raw_r, 8'h00});
            sum_next.g = $signed({{(crgb_pkg::SUM_W-16){1'b0}}, prod_reg.raw_g, 8'h00});
            sum_next.b = $signed({{(crgb_pkg::SUM_W-16){1'b0}}, prod_reg.raw_b, 8'h00});
        end
        else
        begin
            sum_next.r = prod_reg.p_y + prod_reg.p_rv + crgb_pkg::ROUND;
            sum_next.g = prod_reg.p_y - prod_reg.p_gu - prod_reg.p_gv + crgb_pkg::ROUND;
            sum_next.b = prod_reg.p_y + prod_reg.p_bu + crgb_pkg::ROUND;
        end
    end

    always_comb
    begin
        out_item_next.red          = crgb_pkg::clamp8(sum_reg.r);
        out_item_next.green        = crgb_pkg::clamp8(sum_reg.g);
        out_item_next.blue         = crgb_pkg::clamp8(sum_reg.b);
        out_item_next.last_of_item = sum_reg.last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
            sum_valid_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (prod_ready)
            begin
                prod_valid_reg <= pix_valid;
            end
            if (sum_ready)
            begin
                sum_valid_reg <= prod_valid_reg;
            end
            if (out_ready)
            begin
                out_valid_reg <= sum_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (prod_ready)
        begin
            prod_reg <= prod_next;
        end
        if (sum_ready)
        begin
            sum_reg <= sum_next;
        end
        if (out_ready)
        begin
            out_item_reg <= out_item_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

// ----- rtl/crgb_checker.sv -----
`timescale 1ns / 1ps

module crgb_checker
(
    input logic                clk,
    input logic                rst_n,
    input logic                out_valid,
    input logic                out_stall,
    input crgb_pkg::out_item_t out_item
);

    // The output register is cleared while reset is held.
    a_reset_empty: assert property (@(posedge clk) !rst_n |-> !out_valid)
        else $error("output valid during reset");

    // No item can reach the output right after reset; it must first cross the pipeline registers.
    a_reset_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !out_valid ##1 !out_valid ##1 !out_valid ##1 !out_valid)
        else $error("output valid too early after reset");

    // The two pixels of a YUYV item leave back to back.
    a_pair_adjacent: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !out_item.last_of_item |=>
            out_valid && out_item.last_of_item)
        else $error("second pixel of a pair missing");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_item))
        else $error("stalled output item changed");

endmodule

bind camera_pixel_to_rgb_converter_top crgb_checker u_crgb_checker (.*);
